@@ rtl/timed_signal_event_table_assert.svh @@
// assertion macros for the timed signal event table checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TIMED_SIGNAL_EVENT_TABLE_ASSERT_SVH
`define TIMED_SIGNAL_EVENT_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TSET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TSET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tset_pkg.sv @@
// shared codes, constants and types of the timed signal event table
// no dependencies
package tset_pkg;

  // item modes
  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_OVR     = 3'd1;
  localparam logic [2:0] MODE_RD_PORT = 3'd2;
  localparam logic [2:0] MODE_RD_ADDR = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  // signal codes, also the base register indexes
  localparam logic [2:0] SIG_A040 = 3'd0;
  localparam logic [2:0] SIG_A041 = 3'd1;
  localparam logic [2:0] SIG_P3   = 3'd2;
  localparam logic [2:0] SIG_P5   = 3'd3;
  localparam logic [2:0] SIG_P6   = 3'd4;
  localparam logic [2:0] NUM_BASE = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_PORT = 2'd2;

  // known ports and addresses
  localparam logic [7:0]  PORT_3    = 8'd3;
  localparam logic [7:0]  PORT_5    = 8'd5;
  localparam logic [7:0]  PORT_6    = 8'd6;
  localparam logic [15:0] ADDR_A040 = 16'ha040;
  localparam logic [15:0] ADDR_A041 = 16'ha041;

  // override slot indexes
  localparam logic [1:0] SLOT_P3 = 2'd0;
  localparam logic [1:0] SLOT_P5 = 2'd1;
  localparam logic [1:0] SLOT_P6 = 2'd2;

  // fixed read values
  localparam logic [7:0] DATA_NO_PORT = 8'hff;
  localparam logic [7:0] DATA_NO_ADDR = 8'h00;
  localparam logic [7:0] DATA_NONE    = 8'h00;

  // channel widths
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 104;
  localparam int OUT_W     = 16;

  // query token walking down the cell row
  typedef struct packed {
    logic        active;
    logic [2:0]  sig;
    logic [63:0] now;
    logic [63:0] best;
    logic [7:0]  level;
  } scan_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/tset_cell.sv @@
// one event slot of the cell row: holds one stored event and updates the
// passing query token; depends on tset_pkg
module tset_cell import tset_pkg::*; #(
  parameter int FILL_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [63:0]       wr_time,
  input  logic [2:0]        wr_sig,
  input  logic [7:0]        wr_level,
  input  scan_tok_t         tok_i,
  input  logic [FILL_W-1:0] remain_i,
  output scan_tok_t         tok_o,
  output logic [FILL_W-1:0] remain_o
);

  logic [63:0]       ent_time_r;
  logic [2:0]        ent_sig_r;
  logic [7:0]        ent_level_r;
  scan_tok_t         tok_r, tok_nxt;
  logic [FILL_W-1:0] remain_r, remain_nxt;
  logic              hit;

  // stored event
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_time_r  <= wr_time;
      ent_sig_r   <= wr_sig;
      ent_level_r <= wr_level;
    end
  end

  // match against the token; later slots win ties
  assign hit = tok_i.active && (remain_i != '0) && (ent_sig_r == tok_i.sig)
            && (ent_time_r <= tok_i.now) && (ent_time_r >= tok_i.best);

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.best  = ent_time_r;
      tok_nxt.level = ent_level_r;
    end
    remain_nxt = (remain_i == '0) ? '0 : remain_i - FILL_W'(1);
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      remain_r <= remain_nxt;
    end
  end

  assign tok_o    = tok_r;
  assign remain_o = remain_r;

endmodule

@@ rtl/timed_signal_event_table.sv @@
// Timed signal event table. Items arrive on the in_ stream and each gives one
// result on the out_ stream. Events are stored in a row of EVENT_SLOTS cells;
// a read sends a query token down the row, one cell per clock. A read that
// consults the table passes the injection register, the cell row and the
// result register before its result is loaded into the output register. Adds,
// overrides, clears, unused modes, override hits and unknown ports or
// addresses skip the cell row: their result goes from the result register to
// the output register. The next item is accepted after that load. One item
// is in work at a time; a finished result waits in the output register while
// the next item is taken. Base levels are written through the cfg_ port at
// any time the block is idle; cfg_ready is always high.
// Depends on tset_pkg and tset_cell.
module timed_signal_event_table import tset_pkg::*; #(
  parameter int EVENT_SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // mode[2:0], cycle_stamp[66:3], signal_sel[69:67], byte_value[77:70],
  // port_number[85:78], bus_address[101:86], zero pad[103:102]
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // read_data[7:0], status[9:8], zero pad[15:10]
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int FILL_W = $clog2(EVENT_SLOTS + 1);

  // input fields
  logic [2:0]  f_mode;
  logic [63:0] f_stamp;
  logic [2:0]  f_sig;
  logic [7:0]  f_byte;
  logic [7:0]  f_port;
  logic [15:0] f_addr;

  assign f_mode  = in_tdata[2:0];
  assign f_stamp = in_tdata[66:3];
  assign f_sig   = in_tdata[69:67];
  assign f_byte  = in_tdata[77:70];
  assign f_port  = in_tdata[85:78];
  assign f_addr  = in_tdata[101:86];

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        base_r [0:4];
  logic [7:0]        ovr_level_r [0:2];
  logic [2:0]        ovr_valid_r;
  scan_tok_t         inj_r, inj_nxt;
  logic [FILL_W-1:0] inj_remain_r;
  logic [7:0]        res_data_r, res_data_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_load;
  logic              ev_wr;
  logic              ovr_wr;
  logic              scan_go;
  logic [2:0]        scan_sig;
  logic [7:0]        scan_base;
  logic              port_known;
  logic [1:0]        port_slot;

  scan_tok_t         tok_chain    [0:EVENT_SLOTS];
  logic [FILL_W-1:0] remain_chain [0:EVENT_SLOTS];

  // port to override slot
  always_comb begin
    port_known = 1'b1;
    case (f_port)
      PORT_3:  port_slot = SLOT_P3;
      PORT_5:  port_slot = SLOT_P5;
      PORT_6:  port_slot = SLOT_P6;
      default: begin
        port_slot  = SLOT_P3;
        port_known = 1'b0;
      end
    endcase
  end

  assign scan_base = base_r[scan_sig];

  // next state and item decode
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    in_tready      = 1'b0;
    out_load       = 1'b0;
    ev_wr          = 1'b0;
    ovr_wr         = 1'b0;
    scan_go        = 1'b0;
    scan_sig       = SIG_A040;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_data_nxt   = DATA_NONE;
          res_status_nxt = STAT_OK;
          state_nxt      = ST_DONE;
          case (f_mode)
            MODE_ADD: begin
              if (fill_r == FILL_W'(EVENT_SLOTS)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                ev_wr    = 1'b1;
                fill_nxt = fill_r + FILL_W'(1);
              end
            end
            MODE_OVR: begin
              if (port_known) begin
                ovr_wr = 1'b1;
              end else begin
                res_status_nxt = STAT_BAD_PORT;
              end
            end
            MODE_RD_PORT: begin
              if (!port_known) begin
                res_data_nxt = DATA_NO_PORT;
              end else if (ovr_valid_r[port_slot]) begin
                res_data_nxt = ovr_level_r[port_slot];
              end else begin
                scan_go   = 1'b1;
                scan_sig  = SIG_P3 + {1'b0, port_slot};
                state_nxt = ST_SCAN;
              end
            end
            MODE_RD_ADDR: begin
              if (f_addr == ADDR_A040) begin
                scan_go   = 1'b1;
                scan_sig  = SIG_A040;
                state_nxt = ST_SCAN;
              end else if (f_addr == ADDR_A041) begin
                scan_go   = 1'b1;
                scan_sig  = SIG_A041;
                state_nxt = ST_SCAN;
              end else begin
                res_data_nxt = DATA_NO_ADDR;
              end
            end
            MODE_CLEAR: fill_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (tok_chain[EVENT_SLOTS].active) begin
          res_data_nxt = tok_chain[EVENT_SLOTS].level;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // token injected at the head of the row
  always_comb begin
    inj_nxt        = inj_r;
    inj_nxt.active = 1'b0;
    if (scan_go) begin
      inj_nxt.active = 1'b1;
      inj_nxt.sig    = scan_sig;
      inj_nxt.now    = f_stamp;
      inj_nxt.best   = '0;
      inj_nxt.level  = scan_base;
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      ovr_valid_r  <= '0;
      out_valid_r  <= 1'b0;
      inj_r.active <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      inj_r       <= inj_nxt;
      if (ovr_wr) begin
        ovr_valid_r[port_slot] <= 1'b1;
      end
    end
  end

  // overrides, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_level_r[0] <= '0;
      ovr_level_r[1] <= '0;
      ovr_level_r[2] <= '0;
    end else if (ovr_wr) begin
      ovr_level_r[port_slot] <= f_byte;
    end
  end

  // base level registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[SIG_A040] <= 8'h00;
      base_r[SIG_A041] <= 8'h00;
      base_r[SIG_P3]   <= 8'hff;
      base_r[SIG_P5]   <= 8'hff;
      base_r[SIG_P6]   <= 8'hff;
    end else if (cfg_valid && (cfg_index < NUM_BASE)) begin
      base_r[cfg_index] <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    if (scan_go) begin
      inj_remain_r <= fill_r;
    end
    if (out_load) begin
      out_data_r <= {6'd0, res_status_r, res_data_r};
    end
  end

  // cell row
  assign tok_chain[0]    = inj_r;
  assign remain_chain[0] = inj_remain_r;

  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
    logic cell_wr;
    assign cell_wr = ev_wr && (fill_r == FILL_W'(i));

    tset_cell #(
      .FILL_W (FILL_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (cell_wr),
      .wr_time  (f_stamp),
      .wr_sig   (f_sig),
      .wr_level (f_byte),
      .tok_i    (tok_chain[i]),
      .remain_i (remain_chain[i]),
      .tok_o    (tok_chain[i+1]),
      .remain_o (remain_chain[i+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/tset_checker.sv @@
// port-level checker for the timed signal event table, bound to the top level
// depends on tset_pkg and timed_signal_event_table_assert.svh
`include "timed_signal_event_table_assert.svh"

module tset_checker import tset_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [7:0] backlog_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // items accepted whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlog_r <= '0;
    end else begin
      backlog_r <= backlog_r + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  `TSET_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `TSET_ASSERT_NOW(a_no_extra, out_acc, backlog_r != 8'd0, "result without an accepted item")
  `TSET_ASSERT_NOW(a_backlog, 1'b1, backlog_r <= 8'd2, "more than one item in work and one waiting")
  `TSET_ASSERT_NOW(a_err_zero, out_tvalid && (out_tdata[9:8] != STAT_OK), out_tdata[7:0] == DATA_NONE, "error result with nonzero data")

endmodule

bind timed_signal_event_table tset_checker u_tset_checker (.*);

@@ bench/timed_signal_event_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for timed_signal_event_table: drives command items and
// base-level writes, and checks every reply against its own prediction.
// Depends on tset_pkg and the timed_signal_event_table RTL.
module timed_signal_event_table_tb;
  import tset_pkg::*;

  localparam int EVENT_SLOTS = 32;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] SIG_MAX = 3'd7;
  localparam logic [63:0] STAMP_MAX = 64'hffff_ffff_ffff_ffff;

  // one command item, mode in the lowest bits
  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  port_number;
    logic [7:0]  byte_value;
    logic [2:0]  signal_sel;
    logic [63:0] cycle_stamp;
    logic [2:0]  mode;
  } cmd_t;

  // one reply item, read_data in the lowest bits
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // predicted block state
  logic [63:0] ev_time[EVENT_SLOTS];
  logic [2:0]  ev_sig[EVENT_SLOTS];
  logic [7:0]  ev_level[EVENT_SLOTS];
  int          ev_count;
  logic [7:0]  ovr_level[3];
  bit          ovr_set[3];
  logic [7:0]  base_lvl[NUM_BASE];

  reply_t      replies_due[$];
  int unsigned mismatch_count = 0;

  // traffic shaping
  int unsigned send_gap_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned stall_left = 0;
  bit          quiet_tail = 1'b0;
  bit          allow_port6_ovr = 1'b0;
  logic [63:0] win_base = '0;
  int unsigned win_span = 15;

  timed_signal_event_table #(.EVENT_SLOTS(EVENT_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int override_slot(input logic [7:0] port);
    case (port)
      PORT_3:  return SLOT_P3;
      PORT_5:  return SLOT_P5;
      PORT_6:  return SLOT_P6;
      default: return -1;
    endcase
  endfunction

  // latest event at or before now for this signal, later entry wins a tie
  function automatic logic [7:0] scheduled_level(input logic [2:0] sig,
                                                 input logic [63:0] now);
    logic [7:0]  lvl;
    logic [63:0] best;
    bit          found;
    lvl = base_lvl[sig];
    best = '0;
    found = 1'b0;
    for (int i = 0; i < ev_count; i++) begin
      if (ev_sig[i] == sig && ev_time[i] <= now && (!found || ev_time[i] >= best)) begin
        lvl = ev_level[i];
        best = ev_time[i];
        found = 1'b1;
      end
    end
    return lvl;
  endfunction

  function automatic reply_t event_table_reply(input cmd_t c);
    reply_t r;
    int     slot;
    r.read_data = DATA_NONE;
    r.status = STAT_OK;
    case (c.mode)
      MODE_ADD: begin
        if (ev_count >= EVENT_SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          ev_time[ev_count] = c.cycle_stamp;
          ev_sig[ev_count] = c.signal_sel;
          ev_level[ev_count] = c.byte_value;
          ev_count++;
        end
      end
      MODE_OVR: begin
        slot = override_slot(c.port_number);
        if (slot < 0) begin
          r.status = STAT_BAD_PORT;
        end else begin
          ovr_level[slot] = c.byte_value;
          ovr_set[slot] = 1'b1;
        end
      end
      MODE_RD_PORT: begin
        slot = override_slot(c.port_number);
        if (slot < 0) r.read_data = DATA_NO_PORT;
        else if (ovr_set[slot]) r.read_data = ovr_level[slot];
        else r.read_data = scheduled_level(3'(SIG_P3 + slot), c.cycle_stamp);
      end
      MODE_RD_ADDR: begin
        if (c.bus_address == ADDR_A040) r.read_data = scheduled_level(SIG_A040, c.cycle_stamp);
        else if (c.bus_address == ADDR_A041)
          r.read_data = scheduled_level(SIG_A041, c.cycle_stamp);
        else r.read_data = DATA_NO_ADDR;
      end
      MODE_CLEAR: ev_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void reset_prediction();
    base_lvl[SIG_A040] = 8'h00;
    base_lvl[SIG_A041] = 8'h00;
    base_lvl[SIG_P3] = 8'hff;
    base_lvl[SIG_P5] = 8'hff;
    base_lvl[SIG_P6] = 8'hff;
    ev_count = 0;
    for (int i = 0; i < 3; i++) begin
      ovr_level[i] = 8'h00;
      ovr_set[i] = 1'b0;
    end
  endfunction

  // ------------------------------------------------------------ item builders

  // every field random so unused fields get exercised too
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.mode = 3'($urandom);
    c.cycle_stamp = {$urandom, $urandom};
    c.signal_sel = 3'($urandom);
    c.byte_value = 8'($urandom);
    c.port_number = 8'($urandom);
    c.bus_address = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_t cmd_plain(input logic [2:0] mode);
    cmd_t c;
    c = noise_cmd();
    c.mode = mode;
    return c;
  endfunction

  function automatic cmd_t cmd_add(input logic [63:0] stamp, input logic [2:0] sig,
                                   input logic [7:0] lvl);
    cmd_t c;
    c = cmd_plain(MODE_ADD);
    c.cycle_stamp = stamp;
    c.signal_sel = sig;
    c.byte_value = lvl;
    return c;
  endfunction

  function automatic cmd_t cmd_override(input logic [7:0] port, input logic [7:0] lvl);
    cmd_t c;
    c = cmd_plain(MODE_OVR);
    c.port_number = port;
    c.byte_value = lvl;
    return c;
  endfunction

  function automatic cmd_t cmd_read_port(input logic [63:0] stamp, input logic [7:0] port);
    cmd_t c;
    c = cmd_plain(MODE_RD_PORT);
    c.cycle_stamp = stamp;
    c.port_number = port;
    return c;
  endfunction

  function automatic cmd_t cmd_read_addr(input logic [63:0] stamp, input logic [15:0] addr);
    cmd_t c;
    c = cmd_plain(MODE_RD_ADDR);
    c.cycle_stamp = stamp;
    c.bus_address = addr;
    return c;
  endfunction

  function automatic logic [7:0] unknown_port();
    logic [7:0] p;
    do p = 8'($urandom); while (override_slot(p) >= 0);
    return p;
  endfunction

  function automatic logic [7:0] random_port();
    case ($urandom_range(0, 4))
      0: return PORT_3;
      1: return PORT_5;
      2: return PORT_6;
      3: return PORT_6;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_addr();
    case ($urandom_range(0, 4))
      0, 1: return ADDR_A040;
      2, 3: return ADDR_A041;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] random_signal();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(NUM_BASE, SIG_MAX));
    return 3'($urandom_range(0, NUM_BASE - 1));
  endfunction

  // stamps cluster in a narrow window so ties and boundaries come up often
  function automatic void pick_window();
    case ($urandom_range(0, 2))
      0: win_span = 3;
      1: win_span = 15;
      default: win_span = 63;
    endcase
    case ($urandom_range(0, 3))
      0: win_base = '0;
      1: win_base = {$urandom, $urandom};
      2: win_base = STAMP_MAX - win_span;
      default: win_base = 64'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [63:0] window_stamp();
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    return win_base + 64'($urandom_range(0, win_span));
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------- channel drivers

  task automatic send_cmd(input cmd_t c);
    cfg_valid <= 1'b0;
    if (!quiet_tail && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tdata <= {{(IN_W - $bits(cmd_t)){1'b0}}, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(event_table_reply(c));
  endtask

  // hold off new items until every reply is back, then let the block settle
  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_base(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_BASE) base_lvl[idx] = val;
  endtask

  task automatic rewrite_random_base();
    logic [7:0] val;
    wait_for_replies();
    case ($urandom_range(0, 2))
      0: val = 8'h00;
      1: val = 8'hff;
      default: val = 8'($urandom);
    endcase
    write_base(CFG_IDX_W'($urandom), val);
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet_tail || ready_stall_pct == 0) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < ready_stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------- reply check

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(reply_t)-1:0];
      if (replies_due.size() == 0) begin
        log_mismatch($sformatf("reply with none due: read_data %02h status %0d",
                               got.read_data, got.status));
      end else begin
        want = replies_due.pop_front();
        if (got.read_data !== want.read_data)
          log_mismatch($sformatf("read_data: expected %02h, got %02h",
                                 want.read_data, got.read_data));
        if (got.status !== want.status)
          log_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // levels straight out of reset
  task automatic test_reset_levels();
    send_cmd(cmd_read_port(64'd0, PORT_3));
    send_cmd(cmd_read_port(STAMP_MAX, PORT_5));
    send_cmd(cmd_read_port(64'd7, PORT_6));
    send_cmd(cmd_read_addr(64'd0, ADDR_A040));
    send_cmd(cmd_read_addr(STAMP_MAX, ADDR_A041));
  endtask

  // every base register, extremes, and an index past the last register
  task automatic test_base_registers();
    wait_for_replies();
    write_base(SIG_A040, 8'hff);
    write_base(SIG_A041, 8'h00);
    write_base(SIG_P3, 8'h00);
    write_base(SIG_P5, 8'h81);
    write_base(SIG_P6, 8'hff);
    write_base(SIG_MAX, 8'h33);
    send_cmd(cmd_read_addr(64'd1, ADDR_A040));
    send_cmd(cmd_read_port(64'd1, PORT_3));
    send_cmd(cmd_read_port(64'd1, PORT_5));
  endtask

  // lookup rules: ties, stamp extremes, unknown signal, unknown port and address
  task automatic test_event_lookup();
    send_cmd(cmd_plain(MODE_CLEAR));
    send_cmd(cmd_add(64'd10, SIG_A040, 8'h11));
    send_cmd(cmd_add(64'd10, SIG_A040, 8'h22));
    send_cmd(cmd_add(64'd0, SIG_A040, 8'h01));
    send_cmd(cmd_add(STAMP_MAX, SIG_P5, 8'h55));
    send_cmd(cmd_add(64'd5, SIG_MAX, 8'hee));
    send_cmd(cmd_read_addr(64'd9, ADDR_A040));
    send_cmd(cmd_read_addr(64'd10, ADDR_A040));
    send_cmd(cmd_read_port(STAMP_MAX - 1, PORT_5));
    send_cmd(cmd_read_port(STAMP_MAX, PORT_5));
    send_cmd(cmd_read_addr(64'd20, 16'h1234));
    send_cmd(cmd_read_port(64'd20, 8'd0));
    send_cmd(cmd_plain(MODE_SPARE_LO));
  endtask

  // sticky overrides, kept across a clear
  task automatic test_overrides();
    send_cmd(cmd_override(8'd7, 8'h42));
    send_cmd(cmd_override(PORT_3, 8'h00));
    send_cmd(cmd_override(PORT_5, 8'hff));
    send_cmd(cmd_add(64'd0, SIG_P3, 8'h77));
    send_cmd(cmd_read_port(64'd3, PORT_3));
    send_cmd(cmd_plain(MODE_CLEAR));
    send_cmd(cmd_read_port(64'd0, PORT_5));
    send_cmd(cmd_read_port(64'd0, PORT_6));
    send_cmd(cmd_plain(MODE_SPARE_HI));
  endtask

  // episodes: clear, then a mix of adds, reads, overrides, unused modes and clears in one stamp window
  task automatic run_random_traffic(input int unsigned n_items, input bit with_overrides);
    int unsigned sent;
    int unsigned pick;
    cmd_t        c;
    logic [7:0]  port;
    sent = 0;
    while (sent < n_items) begin
      if (!quiet_tail) begin
        send_gap_pct = pick_pct();
        ready_stall_pct = pick_pct();
        if ($urandom_range(0, 3) == 0) rewrite_random_base();
      end
      pick_window();
      send_cmd(cmd_plain(MODE_CLEAR));
      sent++;
      repeat ($urandom_range(10, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          c = cmd_add(window_stamp(), random_signal(), 8'($urandom));
        end else if (pick < 68) begin
          c = cmd_read_addr(window_stamp(), random_addr());
        end else if (pick < 90) begin
          c = cmd_read_port(window_stamp(), random_port());
        end else if (pick < 94) begin
          c = cmd_plain(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
        end else if (pick < 98) begin
          port = unknown_port();
          if (with_overrides && $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
              0: port = PORT_3;
              1: port = PORT_5;
              default: port = allow_port6_ovr ? PORT_6 : PORT_5;
            endcase
          end
          c = cmd_override(port, 8'($urandom));
        end else begin
          c = cmd_plain(MODE_CLEAR);
        end
        send_cmd(c);
        sent++;
      end
    end
  endtask

  // table lookups for all signals, overrides only to unknown ports
  task automatic test_random_lookup();
    run_random_traffic(900, 1'b0);
  endtask

  // all modes, a full drain midway, and a tail with no idling
  task automatic test_random_mixed();
    run_random_traffic(250, 1'b1);
    wait_for_replies();
    allow_port6_ovr = 1'b1;
    run_random_traffic(200, 1'b1);
    quiet_tail = 1'b1;
    send_gap_pct = 0;
    ready_stall_pct = 0;
    run_random_traffic(150, 1'b1);
  endtask

  initial begin
    reset_prediction();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 15;
    ready_stall_pct = 15;
    test_reset_levels();
    test_base_registers();
    test_event_lookup();
    test_random_lookup();
    test_overrides();
    test_random_mixed();
    wait_for_replies();
    repeat (2 * EVENT_SLOTS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // safety stop far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
